/* sv/rgtr_pkg.sv */
// Shared types and constants of the rotated-grid trilinear resampler.
// No dependencies; imported by the resampler core.
package rgtr_pkg;

    // voxel store address width and depth
    localparam int STORE_AW    = 18;
    localparam int STORE_DEPTH = 1 << STORE_AW;

    // local-grid origin offsets
    localparam int OFS_I = 4;
    localparam int OFS_J = 25;
    localparam int OFS_K = 4;

    // rounding constants
    localparam int ROT_SHIFT = 14;
    localparam int ACC_SHIFT = 24;

    typedef enum logic [2:0] {
        CFG_COS      = 3'd0,
        CFG_SIN      = 3'd1,
        CFG_SRC_X    = 3'd2,
        CFG_SRC_Y    = 3'd3,
        CFG_SRC_Z    = 3'd4,
        CFG_STEP     = 3'd5,
        CFG_BELOW    = 3'd6,
        CFG_OUTSIDE  = 3'd7
    } t_cfg_index;

    typedef logic [STORE_AW-1:0] t_addr;
    typedef logic [15:0]         t_voxel;

endpackage

/* sv/rgtr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgtr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/rotated_grid_trilinear_resampler_core.sv */
// Rotated-grid trilinear resampler: 8-stage pipeline, one request per cycle while the output is not stalled.
// Throughput 1 request/cycle while the output is not stalled,
// set by eight replicated voxel RAMs that give all cell corners in one read.
// Loads write all RAM copies at stage 5, in request order with sample reads.
// Reset (synchronous, active low) clears pipeline valids and sets config registers to defaults;
// voxel contents are not cleared.
module rotated_grid_trilinear_resampler_core
    import rgtr_pkg::*;
#(
    parameter int GLOBAL_X = 64,
    parameter int GLOBAL_Y = 64,
    parameter int GLOBAL_Z = 64,
    parameter int LOCAL_Z  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input requests
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [17:0] i_voxel_addr,
    input  logic [15:0] i_voxel_value,
    input  logic [5:0]  i_local_i,
    input  logic [5:0]  i_local_j,
    input  logic [5:0]  i_local_k,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_velocity,
    output logic        o_outside
);

    localparam int DZ_BELOW = LOCAL_Z - OFS_K;
    localparam logic signed [29:0] LIM_X = 30'((GLOBAL_X - 1) * 256);
    localparam logic signed [29:0] LIM_Y = 30'((GLOBAL_Y - 1) * 256);
    localparam logic signed [29:0] LIM_Z = 30'((GLOBAL_Z - 1) * 256);
    localparam t_addr OFF_X = t_addr'(GLOBAL_Z);
    localparam t_addr OFF_Y = t_addr'(GLOBAL_X * GLOBAL_Z);

    // configuration registers
    logic signed [15:0] r_cos, r_sin;
    logic [14:0]        r_src_x, r_src_y, r_src_z;
    logic [12:0]        r_step;
    logic               r_below;
    logic [15:0]        r_outside_value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos           <= 16'sd16384;
            r_sin           <= '0;
            r_src_x         <= '0;
            r_src_y         <= '0;
            r_src_z         <= '0;
            r_step          <= 13'd256;
            r_below         <= 1'b0;
            r_outside_value <= 16'd26;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_COS:     r_cos           <= i_cfg_data;
                CFG_SIN:     r_sin           <= i_cfg_data;
                CFG_SRC_X:   r_src_x         <= i_cfg_data[14:0];
                CFG_SRC_Y:   r_src_y         <= i_cfg_data[14:0];
                CFG_SRC_Z:   r_src_z         <= i_cfg_data[14:0];
                CFG_STEP:    r_step          <= i_cfg_data[12:0];
                CFG_BELOW:   r_below         <= i_cfg_data[0];
                CFG_OUTSIDE: r_outside_value <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // pipeline advances when the output register is free or drained
    logic w_adv;
    logic r_v8;
    assign w_adv      = !r_v8 || !i_out_stall;
    assign o_in_stall = !w_adv;

    // stage 1: local offsets scaled by the step
    logic signed [11:0] w_dx, w_dy, w_dz;
    logic signed [13:0] w_step;
    logic               r_v1, r_k1;
    t_addr              r_la1;
    t_voxel             r_ld1;
    logic signed [25:0] r_xl, r_yl, r_zl;

    assign w_dx   = $signed({6'b0, i_local_i}) - 12'(OFS_I);
    assign w_dy   = $signed({6'b0, i_local_j}) - 12'(OFS_J);
    assign w_dz   = r_below ? $signed({6'b0, i_local_k}) - 12'(DZ_BELOW)
                            : $signed({6'b0, i_local_k}) - 12'(OFS_K);
    assign w_step = $signed({1'b0, r_step});

    // stage 2: rotation products, absolute z
    logic               r_v2, r_k2;
    t_addr              r_la2;
    t_voxel             r_ld2;
    logic signed [41:0] r_pcx, r_psy, r_psx, r_pcy;
    logic signed [29:0] r_z2;

    // stage 3: rotated point and bounds test
    logic signed [42:0] w_sx, w_sy;
    logic signed [29:0] w_x, w_y;
    logic               r_v3, r_k3, r_in3;
    t_addr              r_la3;
    t_voxel             r_ld3;
    logic [17:0]        r_x3, r_y3, r_z3;

    assign w_sx = 43'(r_pcx) - 43'(r_psy) + 43'sd8192;
    assign w_sy = 43'(r_psx) + 43'(r_pcy) + 43'sd8192;
    assign w_x  = 30'(w_sx >>> ROT_SHIFT) + $signed({15'b0, r_src_x});
    assign w_y  = 30'(w_sy >>> ROT_SHIFT) + $signed({15'b0, r_src_y});

    // stage 4: base address and fractions
    t_addr       w_base;
    logic        r_v4, r_k4, r_in4;
    t_addr       r_la4, r_base;
    t_voxel      r_ld4;
    logic [7:0]  r_fx, r_fy, r_fz;

    assign w_base = t_addr'((t_addr'(r_y3[17:8]) * t_addr'(GLOBAL_X) + t_addr'(r_x3[17:8]))
                            * t_addr'(GLOBAL_Z) + t_addr'(r_z3[17:8]));

    // stage 5: corner reads, loads write, x*y weights
    logic [8:0]  w_wx [2];
    logic [8:0]  w_wy [2];
    logic [8:0]  w_wz [2];
    t_addr       w_caddr [8];
    t_voxel      w_rd [8];
    logic        w_we;
    logic        r_v5, r_in5;
    logic [16:0] r_wxy [4];
    logic [8:0]  r_wz5 [2];

    assign w_wx[0] = 9'd256 - {1'b0, r_fx};
    assign w_wx[1] = {1'b0, r_fx};
    assign w_wy[0] = 9'd256 - {1'b0, r_fy};
    assign w_wy[1] = {1'b0, r_fy};
    assign w_wz[0] = 9'd256 - {1'b0, r_fz};
    assign w_wz[1] = {1'b0, r_fz};
    assign w_we    = w_adv && r_v4 && !r_k4;

    // one RAM copy per corner: bit0 x, bit1 y, bit2 z
    for (genvar c = 0; c < 8; c++) begin : g_corner
        assign w_caddr[c] = r_base + (c[0] ? OFF_X : '0) + (c[1] ? OFF_Y : '0)
                            + (c[2] ? t_addr'(1) : '0);
        rgtr_ram #(
            .WIDTH(16),
            .DEPTH(STORE_DEPTH)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_we),
            .i_waddr(r_la4),
            .i_wdata(r_ld4),
            .i_re   (w_adv),
            .i_raddr(w_caddr[c]),
            .o_rdata(w_rd[c])
        );
    end

    // stage 6: voxel times x*y weight
    logic        r_v6, r_in6;
    logic [32:0] r_m [8];
    logic [8:0]  r_wz6 [2];

    // stage 7: times z weight
    logic        r_v7, r_in7;
    logic [39:0] r_t [8];

    // stage 8: sum and round
    logic [42:0] w_sum;
    logic [15:0] r_vel;
    logic        r_out8;

    always_comb begin
        w_sum = 43'd1 << (ACC_SHIFT - 1);
        for (int c = 0; c < 8; c++) begin
            w_sum = w_sum + 43'(r_t[c]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4 && r_k4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_k1  <= i_kind;
            r_la1 <= i_voxel_addr;
            r_ld1 <= i_voxel_value;
            r_xl  <= w_dx * w_step;
            r_yl  <= w_dy * w_step;
            r_zl  <= w_dz * w_step;

            r_k2  <= r_k1;
            r_la2 <= r_la1;
            r_ld2 <= r_ld1;
            r_pcx <= r_cos * 42'(r_xl);
            r_psy <= r_sin * 42'(r_yl);
            r_psx <= r_sin * 42'(r_xl);
            r_pcy <= r_cos * 42'(r_yl);
            r_z2  <= 30'(r_zl) + $signed({15'b0, r_src_z});

            r_k3  <= r_k2;
            r_la3 <= r_la2;
            r_ld3 <= r_ld2;
            r_in3 <= (w_x >= 0) && (w_x < LIM_X) && (w_y >= 0) && (w_y < LIM_Y)
                     && (r_z2 >= 0) && (r_z2 < LIM_Z);
            r_x3  <= w_x[17:0];
            r_y3  <= w_y[17:0];
            r_z3  <= r_z2[17:0];

            r_k4   <= r_k3;
            r_la4  <= r_la3;
            r_ld4  <= r_ld3;
            r_in4  <= r_in3;
            r_base <= w_base;
            r_fx   <= r_x3[7:0];
            r_fy   <= r_y3[7:0];
            r_fz   <= r_z3[7:0];

            r_in5 <= r_in4;
            for (int c = 0; c < 4; c++) begin
                r_wxy[c] <= 17'(w_wx[c % 2] * w_wy[c / 2]);
            end
            r_wz5 <= w_wz;

            r_in6 <= r_in5;
            for (int c = 0; c < 8; c++) begin
                r_m[c] <= 33'(w_rd[c]) * 33'(r_wxy[c % 4]);
            end
            r_wz6 <= r_wz5;

            r_in7 <= r_in6;
            for (int c = 0; c < 8; c++) begin
                r_t[c] <= 40'(r_m[c]) * 40'(r_wz6[c / 4]);
            end

            r_out8 <= !r_in7;
            r_vel  <= r_in7 ? w_sum[ACC_SHIFT +: 16] : r_outside_value;
        end
    end

    assign o_out_valid = r_v8;
    assign o_velocity  = r_vel;
    assign o_outside   = r_out8;

`ifndef SYNTHESIS
    // a held pipeline keeps its result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v8 && !w_adv) |=> (r_v8 && $stable(r_vel) && $stable(r_out8)))
        else $error("result changed while held");

    // a load never yields a result
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_v4 && !r_k4) |=> !r_v5)
        else $error("load request produced a result");

    // outside points carry the configured value
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_v7 && !r_in7) |=> (o_outside && o_velocity == r_outside_value))
        else $error("outside value mismatch");
`endif

endmodule
